>>> design/segint_pkg.sv
// segint_pkg: shared constants and types for the segment intersection pipeline.
// Used by segint_front, segint_div_step and segment_intersection; depends on nothing.
package segint_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	// threshold register
	localparam int MIN_DEN_W = 33;
	localparam logic [MIN_DEN_W-1:0] MIN_DEN_RESET = 33'd5000;

	// result coordinate width, fixed by the interface
	localparam int OUT_W = 24;

	// the x and y interpolations run side by side as two lanes
	localparam int N_LANES = 2;
	localparam int LANE_X  = 0;
	localparam int LANE_Y  = 1;

	typedef struct packed {
		logic                hit;
		logic [N_LANES-1:0] neg; // B-A negative in that lane
	} flags_t;

endpackage

>>> design/segint_front.sv
// segint_front: five-stage front end - differences, products, cross sums,
// range tests and threshold compare. Depends on segint_pkg.
module segint_front #(
	parameter int CB = segint_pkg::COORD_BITS_DEF,
	parameter int FB = segint_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [segint_pkg::MIN_DEN_W-1:0]   min_den,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [CB-1:0]               ax,
	input  logic signed [CB-1:0]               ay,
	input  logic signed [CB-1:0]               bx,
	input  logic signed [CB-1:0]               by_coord,
	input  logic signed [CB-1:0]               cx,
	input  logic signed [CB-1:0]               cy,
	input  logic signed [CB-1:0]               dx,
	input  logic signed [CB-1:0]               dy,
	output logic                               dst_valid,
	input  logic                               dst_ready,
	output segint_pkg::flags_t                 dst_flags,
	output logic [2*CB:0]                      dst_d,
	output logic [2*CB:0]                      dst_t,
	output logic [CB+FB-1:0]                   dst_m [segint_pkg::N_LANES],
	output logic signed [CB-1:0]               dst_a [segint_pkg::N_LANES]
);

	localparam int DW   = CB + 1;        // coordinate differences
	localparam int PW   = 2 * DW;        // products
	localparam int XW   = PW + 1;        // cross-product sums
	localparam int MW   = 2 * CB + 1;    // magnitude of a cross sum
	localparam int QW   = CB + FB;       // |B-A| scaled by the fraction bits
	localparam int CMPW = (MW > segint_pkg::MIN_DEN_W) ? MW : segint_pkg::MIN_DEN_W;
	localparam int NL   = segint_pkg::N_LANES;
	localparam int LX   = segint_pkg::LANE_X;
	localparam int LY   = segint_pkg::LANE_Y;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	// stage 1: r = B-A, s = D-C, w = C-A
	logic signed [DW-1:0] r_s1 [NL];
	logic signed [DW-1:0] s_s1 [NL];
	logic signed [DW-1:0] w_s1 [NL];
	logic signed [CB-1:0] a_s1 [NL];

	// stage 2: the six products
	logic signed [PW-1:0] pd0_s2, pd1_s2, pt0_s2, pt1_s2, pu0_s2, pu1_s2;
	logic signed [DW-1:0] r_s2 [NL];
	logic signed [CB-1:0] a_s2 [NL];

	// stage 3: cross sums
	logic signed [XW-1:0] den_s3, tn_s3, un_s3;
	logic signed [DW-1:0] r_s3 [NL];
	logic signed [CB-1:0] a_s3 [NL];

	// stage 4: range tests and magnitudes
	logic                 tu_ok_s4;
	logic [MW-1:0]        dmag_s4, tmag_s4;
	logic [NL-1:0]        neg_s4;
	logic [QW-1:0]        m_s4 [NL];
	logic signed [CB-1:0] a_s4 [NL];

	// stage 5: threshold compare, handed to the divider
	segint_pkg::flags_t   flags_s5;
	logic [MW-1:0]        d_s5, t_s5;
	logic [QW-1:0]        m_s5 [NL];
	logic signed [CB-1:0] a_s5 [NL];

	logic          den_pos, tn_ok, un_ok;
	logic [CB-1:0] rmag [NL];

	// a stage takes a new transfer when empty or when it empties this cycle
	assign rdy_s5   = !v_s5 || dst_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			r_s1[LX] <= DW'(bx) - DW'(ax);
			r_s1[LY] <= DW'(by_coord) - DW'(ay);
			s_s1[LX] <= DW'(dx) - DW'(cx);
			s_s1[LY] <= DW'(dy) - DW'(cy);
			w_s1[LX] <= DW'(cx) - DW'(ax);
			w_s1[LY] <= DW'(cy) - DW'(ay);
			a_s1[LX] <= ax;
			a_s1[LY] <= ay;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			pd0_s2 <= PW'(r_s1[LX]) * PW'(s_s1[LY]);
			pd1_s2 <= PW'(r_s1[LY]) * PW'(s_s1[LX]);
			pt0_s2 <= PW'(w_s1[LX]) * PW'(s_s1[LY]);
			pt1_s2 <= PW'(w_s1[LY]) * PW'(s_s1[LX]);
			pu0_s2 <= PW'(w_s1[LX]) * PW'(r_s1[LY]);
			pu1_s2 <= PW'(w_s1[LY]) * PW'(r_s1[LX]);
			r_s2   <= r_s1;
			a_s2   <= a_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			den_s3 <= XW'(pd0_s2) - XW'(pd1_s2);
			tn_s3  <= XW'(pt0_s2) - XW'(pt1_s2);
			un_s3  <= XW'(pu0_s2) - XW'(pu1_s2);
			r_s3   <= r_s2;
			a_s3   <= a_s2;
		end
	end

	// t and u in [0,1] without dividing: same sign as den and no larger
	always_comb begin
		den_pos = !den_s3[XW-1] && (den_s3 != '0);
		if (den_pos) begin
			tn_ok = !tn_s3[XW-1] && (tn_s3 <= den_s3);
			un_ok = !un_s3[XW-1] && (un_s3 <= den_s3);
		end else begin
			tn_ok = (tn_s3[XW-1] || (tn_s3 == '0)) && (tn_s3 >= den_s3);
			un_ok = (un_s3[XW-1] || (un_s3 == '0)) && (un_s3 >= den_s3);
		end
		for (int i = 0; i < NL; i++) begin
			rmag[i] = CB'(r_s3[i][DW-1] ? -r_s3[i] : r_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			tu_ok_s4 <= tn_ok && un_ok;
			dmag_s4  <= MW'(den_s3[XW-1] ? -den_s3 : den_s3);
			tmag_s4  <= MW'(tn_s3[XW-1] ? -tn_s3 : tn_s3);
			for (int i = 0; i < NL; i++) begin
				neg_s4[i] <= r_s3[i][DW-1];
				m_s4[i]   <= QW'(rmag[i]) << FB;
			end
			a_s4 <= a_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			flags_s5.hit <= tu_ok_s4 && (CMPW'(dmag_s4) > CMPW'(min_den));
			flags_s5.neg <= neg_s4;
			d_s5         <= dmag_s4;
			t_s5         <= tmag_s4;
			m_s5         <= m_s4;
			a_s5         <= a_s4;
		end
	end

	assign dst_valid = v_s5;
	assign dst_flags = flags_s5;
	assign dst_d     = d_s5;
	assign dst_t     = t_s5;
	assign dst_m     = m_s5;
	assign dst_a     = a_s5;

endmodule

>>> design/segint_div_step.sv
// segint_div_step: one quotient bit of floor(m*t/d) for both lanes, registered.
// Depends on segint_pkg.
module segint_div_step #(
	parameter int CB = segint_pkg::COORD_BITS_DEF,
	parameter int FB = segint_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_ready,
	input  segint_pkg::flags_t   src_flags,
	input  logic [2*CB:0]        src_d,
	input  logic [2*CB:0]        src_t,
	input  logic [2*CB:0]        src_rem [segint_pkg::N_LANES],
	input  logic [CB+FB-1:0]     src_q   [segint_pkg::N_LANES],
	input  logic [CB+FB-1:0]     src_m   [segint_pkg::N_LANES],
	input  logic signed [CB-1:0] src_a   [segint_pkg::N_LANES],
	output logic                 dst_valid,
	input  logic                 dst_ready,
	output segint_pkg::flags_t   dst_flags,
	output logic [2*CB:0]        dst_d,
	output logic [2*CB:0]        dst_t,
	output logic [2*CB:0]        dst_rem [segint_pkg::N_LANES],
	output logic [CB+FB-1:0]     dst_q   [segint_pkg::N_LANES],
	output logic [CB+FB-1:0]     dst_m   [segint_pkg::N_LANES],
	output logic signed [CB-1:0] dst_a   [segint_pkg::N_LANES]
);

	localparam int MW = 2 * CB + 1;
	localparam int QW = CB + FB;
	localparam int RW = MW + 2;     // 2*rem + t stays below 3*d when t <= d
	localparam int NL = segint_pkg::N_LANES;

	logic                 vld_sn;
	segint_pkg::flags_t   flags_sn;
	logic [MW-1:0]        d_sn, t_sn;
	logic [MW-1:0]        rem_sn [NL];
	logic [QW-1:0]        q_sn   [NL];
	logic [QW-1:0]        m_sn   [NL];
	logic signed [CB-1:0] a_sn   [NL];

	logic [RW-1:0] d1, d2;
	logic [RW-1:0] cand   [NL];
	logic [MW-1:0] rem_nx [NL];
	logic [1:0]    k      [NL];
	logic [QW-1:0] q_nx   [NL];

	assign src_ready = !vld_sn || dst_ready;

	assign d1 = RW'(src_d);
	assign d2 = d1 << 1;

	// rem = 2*rem + bit*t, then take off d at most twice; q gains the same count
	always_comb begin
		for (int i = 0; i < NL; i++) begin
			cand[i] = (RW'(src_rem[i]) << 1) + (src_m[i][QW-1] ? RW'(src_t) : '0);
			if (cand[i] >= d2) begin
				rem_nx[i] = MW'(cand[i] - d2);
				k[i]      = 2'd2;
			end else if (cand[i] >= d1) begin
				rem_nx[i] = MW'(cand[i] - d1);
				k[i]      = 2'd1;
			end else begin
				rem_nx[i] = MW'(cand[i]);
				k[i]      = 2'd0;
			end
			q_nx[i] = (src_q[i] << 1) + QW'(k[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else if (src_ready) begin
			vld_sn <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready) begin
			flags_sn <= src_flags;
			d_sn     <= src_d;
			t_sn     <= src_t;
			a_sn     <= src_a;
			for (int i = 0; i < NL; i++) begin
				rem_sn[i] <= rem_nx[i];
				q_sn[i]   <= q_nx[i];
				m_sn[i]   <= src_m[i] << 1;
			end
		end
	end

	assign dst_valid = vld_sn;
	assign dst_flags = flags_sn;
	assign dst_d     = d_sn;
	assign dst_t     = t_sn;
	assign dst_rem   = rem_sn;
	assign dst_q     = q_sn;
	assign dst_m     = m_sn;
	assign dst_a     = a_sn;

endmodule

>>> design/segment_intersection.sv
// segment_intersection: top level - threshold register, front end, divider chain
// and output register. Depends on segint_pkg, segint_front, segint_div_step.
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ------------------------------
//  input     in         in_valid / in_stall       ax ay bx by_coord cx cy dx dy
//  result    out        out_valid / out_stall     hit ix iy
//  config    in         cfg_we                    cfg_data (min_denominator)
//
// One transfer in and one out per cycle, sustained while out_stall is low. The
// path runs through five front-end stages, one divider stage per quotient bit,
// and the output register.
// Reset clears every valid bit and loads the threshold with 5000; there is no
// clearing pass. A stall drains into empty stages first, so input is taken
// while a result waits; in_stall rises only once every stage holds a transfer.
module segment_intersection #(
	parameter int COORD_BITS = segint_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = segint_pkg::FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [segint_pkg::MIN_DEN_W-1:0]        cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [COORD_BITS-1:0]            ax,
	input  logic signed [COORD_BITS-1:0]            ay,
	input  logic signed [COORD_BITS-1:0]            bx,
	input  logic signed [COORD_BITS-1:0]            by_coord,
	input  logic signed [COORD_BITS-1:0]            cx,
	input  logic signed [COORD_BITS-1:0]            cy,
	input  logic signed [COORD_BITS-1:0]            dx,
	input  logic signed [COORD_BITS-1:0]            dy,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic                                    hit,
	output logic signed [segint_pkg::OUT_W-1:0]     ix,
	output logic signed [segint_pkg::OUT_W-1:0]     iy
);

	localparam int MW = 2 * COORD_BITS + 1;           // |den| and |tn|
	localparam int QW = COORD_BITS + FRAC_BITS;       // quotient bits = divider stages
	localparam int VW = COORD_BITS + FRAC_BITS + 2;   // A*2^F +/- quotient
	localparam int NL = segint_pkg::N_LANES;
	localparam int OW = segint_pkg::OUT_W;

	// threshold on |den|; the user writes it only while the pipeline is empty (not enforced here)
	logic [segint_pkg::MIN_DEN_W-1:0] min_den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_den_q <= segint_pkg::MIN_DEN_RESET;
		end else if (cfg_we) begin
			min_den_q <= cfg_data;
		end
	end

	// divider chain: index 0 is the front-end output, index QW the last step
	logic                       ch_valid [QW+1];
	logic                       ch_ready [QW+1];
	segint_pkg::flags_t         ch_flags [QW+1];
	logic [MW-1:0]              ch_d     [QW+1];
	logic [MW-1:0]              ch_t     [QW+1];
	logic [MW-1:0]              ch_rem   [QW+1][NL];
	logic [QW-1:0]              ch_q     [QW+1][NL];
	logic [QW-1:0]              ch_m     [QW+1][NL];
	logic signed [COORD_BITS-1:0] ch_a   [QW+1][NL];

	segint_front #(
		.CB(COORD_BITS),
		.FB(FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.min_den   (min_den_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ax        (ax),
		.ay        (ay),
		.bx        (bx),
		.by_coord  (by_coord),
		.cx        (cx),
		.cy        (cy),
		.dx        (dx),
		.dy        (dy),
		.dst_valid (ch_valid[0]),
		.dst_ready (ch_ready[0]),
		.dst_flags (ch_flags[0]),
		.dst_d     (ch_d[0]),
		.dst_t     (ch_t[0]),
		.dst_m     (ch_m[0]),
		.dst_a     (ch_a[0])
	);

	// the long division starts with zero remainder and zero quotient
	always_comb begin
		for (int i = 0; i < NL; i++) begin
			ch_rem[0][i] = '0;
			ch_q[0][i]   = '0;
		end
	end

	for (genvar g = 0; g < QW; g++) begin : g_div
		segint_div_step #(
			.CB(COORD_BITS),
			.FB(FRAC_BITS)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.src_valid (ch_valid[g]),
			.src_ready (ch_ready[g]),
			.src_flags (ch_flags[g]),
			.src_d     (ch_d[g]),
			.src_t     (ch_t[g]),
			.src_rem   (ch_rem[g]),
			.src_q     (ch_q[g]),
			.src_m     (ch_m[g]),
			.src_a     (ch_a[g]),
			.dst_valid (ch_valid[g+1]),
			.dst_ready (ch_ready[g+1]),
			.dst_flags (ch_flags[g+1]),
			.dst_d     (ch_d[g+1]),
			.dst_t     (ch_t[g+1]),
			.dst_rem   (ch_rem[g+1]),
			.dst_q     (ch_q[g+1]),
			.dst_m     (ch_m[g+1]),
			.dst_a     (ch_a[g+1])
		);
	end

	// output register: point = A*2^F +/- quotient, zeroed on a miss,
	// wrapped or sign-extended to the output width
	logic                 out_valid_q;
	logic                 hit_q;
	logic signed [OW-1:0] ix_q, iy_q;
	logic                 out_ready;

	logic signed [VW-1:0] base [NL];
	logic signed [VW-1:0] qe   [NL];
	logic signed [VW-1:0] pt   [NL];
	logic signed [OW-1:0] res  [NL];

	assign out_ready      = !out_valid_q || !out_stall;
	assign ch_ready[QW]   = out_ready;

	always_comb begin
		for (int i = 0; i < NL; i++) begin
			base[i] = VW'(ch_a[QW][i]) <<< FRAC_BITS;
			qe[i]   = VW'(ch_q[QW][i]);
			pt[i]   = ch_flags[QW].neg[i] ? (base[i] - qe[i]) : (base[i] + qe[i]);
			res[i]  = ch_flags[QW].hit ? OW'(pt[i]) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= ch_valid[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			hit_q <= ch_flags[QW].hit;
			ix_q  <= res[segint_pkg::LANE_X];
			iy_q  <= res[segint_pkg::LANE_Y];
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign ix        = ix_q;
	assign iy        = iy_q;

	// a miss carries a zero point
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (ix == '0 && iy == '0))
		else $error("miss result with non-zero point");

	// input back-pressure only once the whole pipe is full behind a stalled result
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while the pipeline could still move");

endmodule
